### sv/gbs_pkg.sv
package gbs_pkg;

  localparam int CoordW = 16;
  localparam int SizeW  = 15;
  localparam int ThrW   = 9;
  localparam int IdxW   = 16;
  localparam int EdgeW  = 17;               // x + w fits in 17 signed bits
  localparam int AreaW  = 30;               // 15 x 15 unsigned
  localparam int UnionW = 31;
  localparam int LhsW   = AreaW + 8;        // inter * 256
  localparam int RhsW   = UnionW + ThrW;    // threshold * union
  localparam logic [ThrW-1:0] ThrReset = 9'd115;

  typedef struct packed {
    logic signed [CoordW-1:0] box_x;
    logic signed [CoordW-1:0] box_y;
    logic [SizeW-1:0]         box_w;
    logic [SizeW-1:0]         box_h;
    logic                     frame_start;
  } in_item_t;

  typedef struct packed {
    logic            keep;
    logic [IdxW-1:0] box_index;
    logic            overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [SizeW-1:0]         w;
    logic [SizeW-1:0]         h;
  } box_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input box
    logic clear;      // frame start: empty list
    logic rd_issue;   // issue memory read for current scan position
    logic cmp_en;     // candidate data valid in the compare pipeline
    logic store;      // append box if kept and room
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // all reads issued
    logic pipe_empty; // no compare in flight
  } dp_stat_t;

endpackage

### sv/greedy_box_suppression_top.sv
// Greedy IoU box suppression.
// in channel (in_valid/in_ready/in_data): one candidate box per transfer,
//   sorted by falling score; frame_start empties the kept list first.
// out channel (out_valid/out_ready/out_data): one result per box: keep,
//   box index within the frame, overflow when kept but the list was full.
// cfg channel (cfg_valid/cfg_ready/cfg_data): iou_threshold in 1/256 units;
//   write only while idle.
// Each box is compared against the kept boxes one per cycle through a
// single-port memory read and a 3-stage overlap/area/multiply pipeline.
// A new box is accepted only once the result of the one before has been stored.
// The finished result sits in an output register; a stalled receiver holds
// the block in its final state until the result register frees.
// Reset: kept list empty, frame index 0, threshold 115, no result pending.
module greedy_box_suppression_top import gbs_pkg::*; #(
  parameter int MAX_KEPT = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [ThrW-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [ThrW-1:0] iou_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold <= ThrReset;
    end else if (cfg_valid && cfg_ready) begin
      iou_threshold <= cfg_data;
    end
  end

  gbs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready,
    .in_frame_start(in_data.frame_start),
    .out_valid, .out_ready, .stat, .cmd
  );

  gbs_datapath #(.MAX_KEPT(MAX_KEPT)) u_dp (
    .clk, .rst, .in_item(in_data), .iou_threshold, .cmd, .stat,
    .result(out_data)
  );

endmodule

### sv/gbs_datapath.sv
module gbs_datapath import gbs_pkg::*; #(
  parameter int MAX_KEPT = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic [ThrW-1:0] iou_threshold,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t result
);

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW = $clog2(MAX_KEPT + 1);

  box_t           mem [MAX_KEPT];
  box_t           cur;
  box_t           rd_data;
  logic [CW-1:0]  count;
  logic [CW-1:0]  scan;
  logic [IdxW-1:0] position;
  logic [IdxW-1:0] index;
  logic           keep;
  logic           v1, v2, v3;

  // stage 1 results
  logic [SizeW:0] iw, ih;
  logic [AreaW-1:0] area_b;
  // stage 2
  logic [AreaW-1:0] inter;
  logic [UnionW-1:0] uni;
  // stage 3
  logic [LhsW-1:0] lhs;
  logic [RhsW-1:0] rhs;

  logic signed [EdgeW-1:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
  logic signed [EdgeW-1:0] lo_x, hi_x, lo_y, hi_y, dx, dy;
  logic [AreaW-1:0] area_a;

  always_comb begin
    ax0 = EdgeW'(cur.x);
    ax1 = EdgeW'(cur.x) + EdgeW'({1'b0, cur.w});
    bx0 = EdgeW'(rd_data.x);
    bx1 = EdgeW'(rd_data.x) + EdgeW'({1'b0, rd_data.w});
    ay0 = EdgeW'(cur.y);
    ay1 = EdgeW'(cur.y) + EdgeW'({1'b0, cur.h});
    by0 = EdgeW'(rd_data.y);
    by1 = EdgeW'(rd_data.y) + EdgeW'({1'b0, rd_data.h});
    lo_x = (ax0 > bx0) ? ax0 : bx0;
    hi_x = (ax1 < bx1) ? ax1 : bx1;
    lo_y = (ay0 > by0) ? ay0 : by0;
    hi_y = (ay1 < by1) ? ay1 : by1;
    dx = hi_x - lo_x;
    dy = hi_y - lo_y;
    area_a = AreaW'(cur.w) * AreaW'(cur.h);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= mem[scan[AW-1:0]];
    end
    if (cmd.store && keep && count < CW'(MAX_KEPT)) begin
      mem[count[AW-1:0]] <= cur;
    end
    iw     <= (dx > 0) ? dx[SizeW:0] : '0;
    ih     <= (dy > 0) ? dy[SizeW:0] : '0;
    area_b <= AreaW'(rd_data.w) * AreaW'(rd_data.h);
    inter  <= AreaW'(iw) * AreaW'(ih);
    uni    <= UnionW'(area_a) + UnionW'(area_b) - UnionW'(AreaW'(iw) * AreaW'(ih));
    lhs    <= {inter, 8'd0};
    rhs    <= RhsW'(iou_threshold) * RhsW'(uni);
    if (cmd.load) begin
      cur <= '{x: in_item.box_x, y: in_item.box_y, w: in_item.box_w, h: in_item.box_h};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      position <= '0;
      scan     <= '0;
      keep     <= 1'b0;
      index    <= '0;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      result   <= '0;
    end else begin
      v1 <= cmd.cmp_en;
      v2 <= v1;
      v3 <= v2;
      if (cmd.load) begin
        keep     <= 1'b1;
        scan     <= '0;
        if (cmd.clear) begin
          count    <= '0;
          index    <= '0;
          position <= IdxW'(1);
        end else begin
          index    <= position;
          position <= position + IdxW'(1);
        end
      end else begin
        if (cmd.rd_issue) scan <= scan + CW'(1);
        if (v3 && RhsW'(lhs) > rhs) keep <= 1'b0;
      end
      if (cmd.store) begin
        result.keep      <= keep;
        result.box_index <= index;
        result.overflow  <= keep && count >= CW'(MAX_KEPT);
        if (keep && count < CW'(MAX_KEPT)) count <= count + CW'(1);
      end
    end
  end

  assign stat.scan_done  = (scan >= count);
  assign stat.pipe_empty = !(v1 || v2 || v3 || cmd.cmp_en);

  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_KEPT))
    else $error("kept count beyond capacity");
  assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> (!result.overflow || result.keep))
    else $error("overflow without keep");
  assert property (@(posedge clk) disable iff (rst) cmd.rd_issue |-> scan < count)
    else $error("read past kept list");

endmodule

### sv/gbs_ctrl.sv
module gbs_ctrl import gbs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_frame_start,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, FINISH} state_t;
  state_t state;
  logic   rd_pend;

  // result register frees when taken; next box may load meanwhile
  assign in_ready = (state == IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = in_valid && in_ready;
    cmd.clear    = cmd.load && in_frame_start;
    cmd.rd_issue = (state == SCAN) && !stat.scan_done;
    cmd.cmp_en   = rd_pend;
    cmd.store    = (state == FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_issue;
      if (cmd.store) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE:   if (cmd.load) state <= SCAN;
        SCAN:   if (stat.scan_done) state <= DRAIN;
        DRAIN:  if (stat.pipe_empty && !rd_pend) state <= FINISH;
        FINISH: if (cmd.store) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.store |-> state == FINISH)
    else $error("store outside finish");
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> state == SCAN)
    else $error("load did not start scan");
  assert property (@(posedge clk) disable iff (rst)
    (state == FINISH && out_valid && !out_ready) |=> state == FINISH)
    else $error("result overwritten under stall");

endmodule

### bench/tb_greedy_box_suppression_top.sv
module tb_greedy_box_suppression_top;
  import gbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ListDepth = 64;
  localparam int StallLimit = 20000;
  localparam int DrainCycles = 100;

  class suppression_tracker;
    box_t      kept[ListDepth];
    int        kept_n;
    int        position;
    int        threshold;
    out_item_t verdicts[$];
    int        errors;

    function new();
      kept_n = 0;
      position = 0;
      threshold = ThrReset;
      errors = 0;
    endfunction

    function longint span(longint a0, longint a1, longint b0, longint b1);
      longint d;
      d = ((a1 < b1) ? a1 : b1) - ((a0 > b0) ? a0 : b0);
      return (d > 0) ? d : 0;
    endfunction

    // work out the verdict for an accepted box and queue it
    function void note_box(in_item_t b);
      longint ax, ay, aw, ah, bx, by, bw, bh, inter, uni;
      out_item_t v;
      bit keep;
      ax = longint'($signed(b.box_x));
      ay = longint'($signed(b.box_y));
      aw = longint'(b.box_w);
      ah = longint'(b.box_h);
      keep = 1;
      if (b.frame_start) begin
        kept_n = 0;
        position = 0;
      end
      v.box_index = position[IdxW-1:0];
      position = (position + 1) & 16'hFFFF;
      for (int j = 0; j < kept_n; j++) begin
        bx = longint'($signed(kept[j].x));
        by = longint'($signed(kept[j].y));
        bw = longint'(kept[j].w);
        bh = longint'(kept[j].h);
        inter = span(ax, ax + aw, bx, bx + bw) * span(ay, ay + ah, by, by + bh);
        uni = aw * ah + bw * bh - inter;
        if (inter * 256 > longint'(threshold) * uni) keep = 0;
      end
      v.overflow = 0;
      if (keep) begin
        if (kept_n < ListDepth) begin
          kept[kept_n] = '{x: b.box_x, y: b.box_y, w: b.box_w, h: b.box_h};
          kept_n++;
        end else begin
          v.overflow = 1;
        end
      end
      v.keep = keep;
      verdicts.insert(verdicts.size(), v);
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t want;
      if (verdicts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: keep=%0d index=%0d overflow=%0d",
                                   got.keep, got.box_index, got.overflow);
        return;
      end
      want = verdicts.pop_front();
      if (got.keep !== want.keep || got.box_index !== want.box_index ||
          got.overflow !== want.overflow) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected keep=%0d index=%0d overflow=%0d,",
                    " got keep=%0d index=%0d overflow=%0d"},
                   want.keep, want.box_index, want.overflow,
                   got.keep, got.box_index, got.overflow);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [ThrW-1:0] cfg_data = '0;

  suppression_tracker sb = new();
  bit tx_burst = 0;
  bit rx_burst = 0;
  bit hold_req = 0;
  int quiet_cycles = 0;
  int cx[4], cy[4];

  greedy_box_suppression_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_verdict(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("greedy_box_suppression_top test failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int n;
    @(negedge clk iff !rst);
    forever begin
      if (hold_req) begin
        out_ready = 0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end
      n = rx_burst ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_ready = 0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic in_item_t make_box(int x, int y, int w, int h, bit fs);
    in_item_t b;
    b.box_x = x[15:0];
    b.box_y = y[15:0];
    b.box_w = w[14:0];
    b.box_h = h[14:0];
    b.frame_start = fs;
    return b;
  endfunction

  task automatic send_box(in_item_t b);
    int n;
    n = tx_burst ? 0 : $urandom_range(0, 10);
    repeat (n) @(negedge clk);
    in_valid = 1;
    in_data = b;
    do @(posedge clk); while (!in_ready);
    sb.note_box(b);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic write_threshold(int v);
    cfg_valid = 1;
    cfg_data = v[ThrW-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.threshold = v & 9'h1FF;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic settle();
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  // clustered, disjoint-grid or fully random boxes
  function automatic in_item_t random_box(bit fs, int seq);
    int k, mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      k = $urandom_range(0, 3);
      return make_box(cx[k] + $urandom_range(0, 64) - 32, cy[k] + $urandom_range(0, 64) - 32,
                      $urandom_range(200, 400), $urandom_range(200, 400), fs);
    end else if (mode < 8) begin
      return make_box((seq % 40) * 800 - 16000, $urandom_range(0, 1) * 20000 - 10000,
                      $urandom_range(0, 500), $urandom_range(0, 500), fs);
    end
    return make_box($urandom, $urandom, $urandom_range(0, 32767), $urandom_range(0, 32767), fs);
  endfunction

  initial begin
    int thr_list[6];
    int items;
    bit fs;
    thr_list = '{115, 0, 256, 511, 0, 115};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed part at reset threshold
    send_box(make_box(0, 0, 160, 160, 1));
    send_box(make_box(0, 0, 160, 160, 0));          // identical: suppressed
    send_box(make_box(160, 0, 160, 160, 0));        // touching: kept
    send_box(make_box(40, 40, 160, 160, 0));        // partial overlap
    send_box(make_box(10, 10, 0, 50, 0));           // zero area
    send_box(make_box(-32768, -32768, 32767, 32767, 0));
    send_box(make_box(32767, 32767, 32767, 32767, 0));
    send_box(make_box(-32768, 32767, 0, 32767, 0));
    send_box(make_box(-1, -1, 1, 1, 0));
    send_box(make_box(5000, 5000, 0, 0, 1));
    send_box(make_box(5000, 5000, 0, 0, 0));        // both zero area
    settle();
    write_threshold(0);
    send_box(make_box(0, 0, 100, 100, 1));
    send_box(make_box(99, 99, 100, 100, 0));        // any overlap suppresses
    send_box(make_box(100, 0, 100, 100, 0));
    send_box(make_box(300, 300, 0, 0, 0));
    send_box(make_box(300, 300, 0, 0, 0));
    settle();
    write_threshold(256);
    send_box(make_box(0, 0, 100, 100, 1));
    send_box(make_box(0, 0, 100, 100, 0));          // nothing suppressed
    settle();
    // overflow: more disjoint boxes than the list holds
    write_threshold(115);
    for (int i = 0; i < 70; i++)
      send_box(make_box(i * 400 - 14000, 0, 200, 200, i == 0));
    settle();

    foreach (thr_list[p]) begin
      write_threshold(p == 4 ? $urandom_range(1, 255) : thr_list[p]);
      if (p == 1) hold_req = 1;
      items = 0;
      while (items < 200) begin
        if (items % 50 == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_burst = ($urandom_range(0, 3) == 0);
        end
        fs = (items == 0) || ($urandom_range(0, 59) == 0);
        if (fs) begin
          foreach (cx[k]) begin
            cx[k] = $urandom_range(0, 40000) - 20000;
            cy[k] = $urandom_range(0, 40000) - 20000;
          end
        end
        send_box(random_box(fs, items));
        items++;
      end
      settle();
    end

    if (sb.errors == 0 && sb.verdicts.size() == 0) begin
      $display("greedy_box_suppression_top test passed");
    end else begin
      $display("greedy_box_suppression_top test failed");
    end
    $finish;
  end
endmodule
